// ----- hw/rtl/lcdseq_pkg.sv -----
// Shared types and constants for the character LCD nibble bus sequencer.
`timescale 1ns / 1ps

package lcdseq_pkg;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [2:0] MODE_TICK    = 3'd0;
	localparam logic [2:0] MODE_BYTE    = 3'd1;
	localparam logic [2:0] MODE_DIGIT   = 3'd2;
	localparam logic [2:0] MODE_COMMAND = 3'd3;
	localparam logic [2:0] MODE_RESTART = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_SET  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_CTRL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_MODE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP_DLY  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_NIB_DLY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_DLY    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_DLY     = 3'd6;

	localparam logic [7:0]  RST_FUNCTION_SET  = 8'd40;
	localparam logic [7:0]  RST_DISPLAY_CTRL  = 8'd12;
	localparam logic [7:0]  RST_ENTRY_MODE    = 8'd6;
	localparam logic [15:0] RST_POWER_UP_DLY  = 16'd50000;
	localparam logic [15:0] RST_RESET_NIB_DLY = 16'd4500;
	localparam logic [15:0] RST_SETTLE_DLY    = 16'd100;
	localparam logic [15:0] RST_CLEAR_DLY     = 16'd2000;

	localparam logic [3:0]  RESET_NIBBLE     = 4'h3;
	localparam logic [3:0]  FOUR_BIT_NIBBLE  = 4'h2;
	localparam logic [15:0] THIRD_RESET_WAIT = 16'd150;
	localparam logic [7:0]  CLEAR_COMMAND    = 8'h01;
	localparam logic [7:0]  DIGIT_OFFSET     = 8'd48;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_TICK,
		KIND_SEND,
		KIND_RESTART
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic       rs;
	} entry_t;

	typedef enum logic [4:0] {
		ST_START = 5'd0,
		ST_PWR   = 5'd1,
		ST_R1    = 5'd2,
		ST_R2    = 5'd3,
		ST_R3    = 5'd4,
		ST_N2    = 5'd5,
		ST_FS_H  = 5'd6,
		ST_FS_L  = 5'd7,
		ST_DC_H  = 5'd8,
		ST_DC_L  = 5'd9,
		ST_CL_H  = 5'd10,
		ST_CL_L  = 5'd11,
		ST_EM_H  = 5'd12,
		ST_EM_L  = 5'd13,
		ST_IDLE  = 5'd14,
		ST_TX_H  = 5'd15,
		ST_TX_L  = 5'd16
	} step_t;

	typedef enum logic [1:0] {
		PH_WAIT    = 2'd0,
		PH_EN_LOW  = 2'd1,
		PH_EN_HIGH = 2'd2,
		PH_SETTLE  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0]  function_set;
		logic [7:0]  display_ctrl;
		logic [7:0]  entry_mode;
		logic [15:0] power_up_dly;
		logic [15:0] reset_nib_dly;
		logic [15:0] settle_dly;
		logic [15:0] clear_dly;
	} cfg_t;

endpackage

// ----- hw/rtl/lcdseq_front.sv -----
// Request decoder: classifies stream requests into queue entries.
`timescale 1ns / 1ps

module lcdseq_front (
	input  logic [lcdseq_pkg::IN_DATA_W-1:0] s_tdata,
	output lcdseq_pkg::entry_t               entry
);

	logic [2:0] mode;
	logic [7:0] data_byte;

	assign mode      = s_tdata[2:0];
	assign data_byte = s_tdata[10:3];

	always_comb begin
		entry.kind      = lcdseq_pkg::KIND_NONE;
		entry.data_byte = data_byte;
		entry.rs        = 1'b1;
		unique case (mode)
			lcdseq_pkg::MODE_TICK: begin
				entry.kind = lcdseq_pkg::KIND_TICK;
			end
			lcdseq_pkg::MODE_BYTE: begin
				entry.kind = lcdseq_pkg::KIND_SEND;
			end
			lcdseq_pkg::MODE_DIGIT: begin
				entry.kind      = lcdseq_pkg::KIND_SEND;
				entry.data_byte = 8'(data_byte + lcdseq_pkg::DIGIT_OFFSET);
			end
			lcdseq_pkg::MODE_COMMAND: begin
				entry.kind = lcdseq_pkg::KIND_SEND;
				entry.rs   = 1'b0;
			end
			lcdseq_pkg::MODE_RESTART: begin
				entry.kind = lcdseq_pkg::KIND_RESTART;
			end
			default: begin
				entry.kind = lcdseq_pkg::KIND_NONE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/lcdseq_queue.sv -----
// Two-entry queue between the request decoder and the bus sequencer.
`timescale 1ns / 1ps

module lcdseq_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lcdseq_pkg::entry_t in_entry,
	output logic               out_valid,
	input  logic               out_ready,
	output lcdseq_pkg::entry_t out_entry
);

	lcdseq_pkg::entry_t mem_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               push;
	logic               pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_entry = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_q[0] <= '0;
			mem_q[1] <= '0;
		end else if (push) begin
			mem_q[wr_ptr_q] <= in_entry;
		end
	end

endmodule

// ----- hw/rtl/lcdseq_back.sv -----
// Bus sequencer: power-up sequence, nibble strobes, delay counting and results.
`timescale 1ns / 1ps

module lcdseq_back #(
	parameter int DELAY_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	output logic                               q_ready,
	input  lcdseq_pkg::entry_t                 q_entry,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lcdseq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lcdseq_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lcdseq_pkg::OUT_DATA_W-1:0]  m_tdata
);

	localparam int WW = (DELAY_BITS > 16) ? DELAY_BITS : 16;
	localparam logic [WW-1:0] WAIT_MAX = WW'({DELAY_BITS{1'b1}});

	typedef struct packed {
		lcdseq_pkg::step_t     step;
		lcdseq_pkg::phase_t    phase;
		logic [DELAY_BITS-1:0] wait_cnt;
		logic [7:0]            held_byte;
		logic                  held_rs;
		logic [3:0]            pin;
	} seq_t;

	lcdseq_pkg::cfg_t cfg_q;
	seq_t             st_q;
	seq_t             st_nxt;
	logic             acc_nxt;
	logic             fire;
	logic             out_valid_q;
	logic [lcdseq_pkg::OUT_DATA_W-1:0] out_data_q;

	function automatic logic [DELAY_BITS-1:0] clamp_wait(input logic [15:0] v);
		logic [WW-1:0] vx;
		vx = WW'(v);
		if (vx > WAIT_MAX) begin
			return {DELAY_BITS{1'b1}};
		end
		return DELAY_BITS'(vx);
	endfunction

	function automatic logic [7:0] step_byte(input lcdseq_pkg::step_t s, input logic [7:0] held,
			input lcdseq_pkg::cfg_t c);
		logic [7:0] b;
		b = 8'd0;
		unique case (s)
			lcdseq_pkg::ST_FS_H, lcdseq_pkg::ST_FS_L: b = c.function_set;
			lcdseq_pkg::ST_DC_H, lcdseq_pkg::ST_DC_L: b = c.display_ctrl;
			lcdseq_pkg::ST_CL_H, lcdseq_pkg::ST_CL_L: b = lcdseq_pkg::CLEAR_COMMAND;
			lcdseq_pkg::ST_EM_H, lcdseq_pkg::ST_EM_L: b = c.entry_mode;
			lcdseq_pkg::ST_TX_H, lcdseq_pkg::ST_TX_L: b = held;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

	function automatic logic [15:0] step_extra(input lcdseq_pkg::step_t s,
			input lcdseq_pkg::cfg_t c);
		logic [15:0] e;
		e = 16'd0;
		if (s == lcdseq_pkg::ST_R1 || s == lcdseq_pkg::ST_R2) begin
			e = c.reset_nib_dly;
		end else if (s == lcdseq_pkg::ST_R3) begin
			e = lcdseq_pkg::THIRD_RESET_WAIT;
		end else if (s == lcdseq_pkg::ST_CL_L) begin
			e = c.clear_dly;
		end
		return e;
	endfunction

	function automatic lcdseq_pkg::step_t step_next(input lcdseq_pkg::step_t s);
		if (s == lcdseq_pkg::ST_EM_L || s >= lcdseq_pkg::ST_TX_L) begin
			return lcdseq_pkg::ST_IDLE;
		end
		return lcdseq_pkg::step_t'(s + 5'd1);
	endfunction

	function automatic seq_t enter_step(input seq_t r_in, input lcdseq_pkg::step_t s,
			input lcdseq_pkg::cfg_t c);
		seq_t       r;
		logic       low;
		logic [7:0] b;
		r   = r_in;
		low = (s == lcdseq_pkg::ST_FS_L) || (s == lcdseq_pkg::ST_DC_L) ||
			(s == lcdseq_pkg::ST_CL_L) || (s == lcdseq_pkg::ST_EM_L) ||
			(s == lcdseq_pkg::ST_TX_L);
		b   = step_byte(s, r_in.held_byte, c);
		if (s == lcdseq_pkg::ST_IDLE || s < lcdseq_pkg::ST_R1 || s > lcdseq_pkg::ST_TX_L) begin
			r.step     = lcdseq_pkg::ST_IDLE;
			r.phase    = lcdseq_pkg::PH_WAIT;
			r.wait_cnt = '0;
		end else begin
			r.step = s;
			if (s <= lcdseq_pkg::ST_R3) begin
				r.pin = lcdseq_pkg::RESET_NIBBLE;
			end else if (s == lcdseq_pkg::ST_N2) begin
				r.pin = lcdseq_pkg::FOUR_BIT_NIBBLE;
			end else begin
				r.pin = low ? b[3:0] : b[7:4];
			end
			r.phase    = lcdseq_pkg::PH_EN_LOW;
			r.wait_cnt = DELAY_BITS'(1);
		end
		return r;
	endfunction

	function automatic seq_t advance(input seq_t r_in, input lcdseq_pkg::cfg_t c);
		seq_t        r;
		logic [15:0] e;
		r = r_in;
		e = step_extra(r_in.step, c);
		unique case (r_in.phase)
			lcdseq_pkg::PH_EN_LOW: begin
				r.phase    = lcdseq_pkg::PH_EN_HIGH;
				r.wait_cnt = DELAY_BITS'(1);
			end
			lcdseq_pkg::PH_EN_HIGH: begin
				r.phase    = lcdseq_pkg::PH_SETTLE;
				r.wait_cnt = clamp_wait(c.settle_dly);
			end
			lcdseq_pkg::PH_SETTLE: begin
				if (e != 16'd0) begin
					r.phase    = lcdseq_pkg::PH_WAIT;
					r.wait_cnt = clamp_wait(e);
				end else begin
					r = enter_step(r_in, step_next(r_in.step), c);
				end
			end
			lcdseq_pkg::PH_WAIT: begin
				r = enter_step(r_in, step_next(r_in.step), c);
			end
		endcase
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign fire      = q_valid && (!out_valid_q || m_tready);
	assign q_ready   = fire;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	always_comb begin
		st_nxt  = st_q;
		acc_nxt = 1'b0;
		unique case (q_entry.kind)
			lcdseq_pkg::KIND_TICK: begin
				if (st_q.step != lcdseq_pkg::ST_IDLE) begin
					if (st_nxt.step == lcdseq_pkg::ST_START) begin
						st_nxt.step     = lcdseq_pkg::ST_PWR;
						st_nxt.phase    = lcdseq_pkg::PH_WAIT;
						st_nxt.held_rs  = 1'b0;
						st_nxt.wait_cnt = clamp_wait(cfg_q.power_up_dly);
					end
					if (st_nxt.wait_cnt != '0) begin
						st_nxt.wait_cnt = st_nxt.wait_cnt - DELAY_BITS'(1);
					end
					// zero waits chain at most three actions
					for (int i = 0; i < 3; i++) begin
						if (st_nxt.step != lcdseq_pkg::ST_IDLE && st_nxt.wait_cnt == '0) begin
							st_nxt = advance(st_nxt, cfg_q);
						end
					end
				end
			end
			lcdseq_pkg::KIND_SEND: begin
				if (st_q.step == lcdseq_pkg::ST_IDLE) begin
					st_nxt.held_byte = q_entry.data_byte;
					st_nxt.held_rs   = q_entry.rs;
					st_nxt           = enter_step(st_nxt, lcdseq_pkg::ST_TX_H, cfg_q);
					acc_nxt          = 1'b1;
				end
			end
			lcdseq_pkg::KIND_RESTART: begin
				if (st_q.step == lcdseq_pkg::ST_IDLE) begin
					st_nxt.step     = lcdseq_pkg::ST_START;
					st_nxt.phase    = lcdseq_pkg::PH_WAIT;
					st_nxt.wait_cnt = '0;
					st_nxt.held_rs  = 1'b0;
					acc_nxt         = 1'b1;
				end
			end
			lcdseq_pkg::KIND_NONE: begin
				acc_nxt = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.step      <= lcdseq_pkg::ST_START;
			st_q.phase     <= lcdseq_pkg::PH_WAIT;
			st_q.wait_cnt  <= '0;
			st_q.held_byte <= 8'd0;
			st_q.held_rs   <= 1'b0;
			st_q.pin       <= 4'd0;
			out_valid_q    <= 1'b0;
		end else begin
			if (fire) begin
				st_q        <= st_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {acc_nxt, (st_nxt.step != lcdseq_pkg::ST_IDLE), st_nxt.pin,
				(st_nxt.phase == lcdseq_pkg::PH_EN_HIGH), st_nxt.held_rs};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.function_set  <= lcdseq_pkg::RST_FUNCTION_SET;
			cfg_q.display_ctrl  <= lcdseq_pkg::RST_DISPLAY_CTRL;
			cfg_q.entry_mode    <= lcdseq_pkg::RST_ENTRY_MODE;
			cfg_q.power_up_dly  <= lcdseq_pkg::RST_POWER_UP_DLY;
			cfg_q.reset_nib_dly <= lcdseq_pkg::RST_RESET_NIB_DLY;
			cfg_q.settle_dly    <= lcdseq_pkg::RST_SETTLE_DLY;
			cfg_q.clear_dly     <= lcdseq_pkg::RST_CLEAR_DLY;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lcdseq_pkg::CFG_FUNCTION_SET:  cfg_q.function_set  <= cfg_data[7:0];
				lcdseq_pkg::CFG_DISPLAY_CTRL:  cfg_q.display_ctrl  <= cfg_data[7:0];
				lcdseq_pkg::CFG_ENTRY_MODE:    cfg_q.entry_mode    <= cfg_data[7:0];
				lcdseq_pkg::CFG_POWER_UP_DLY:  cfg_q.power_up_dly  <= cfg_data;
				lcdseq_pkg::CFG_RESET_NIB_DLY: cfg_q.reset_nib_dly <= cfg_data;
				lcdseq_pkg::CFG_SETTLE_DLY:    cfg_q.settle_dly    <= cfg_data;
				lcdseq_pkg::CFG_CLEAR_DLY:     cfg_q.clear_dly     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/char_lcd_nibble_bus_sequencer.sv -----
// Top level of the character LCD 4-bit bus sequencer.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-----------------------------------
//   s_*      | in        | s_tvalid/s_tready  | mode, data_byte
//   m_*      | out       | m_tvalid/m_tready  | rs, enable, nibble, busy, accepted
//   cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request per cycle sustained while the output is not stalled; a request passes
// through the two-entry queue and the sequencer into the output register.
// The sequencer state update for a tick, including chained zero waits, is registered with its result.
// A stalled output holds its result while the queue keeps taking requests until full.
// Reset starts the power-up sequence; the configuration port is always ready.
`timescale 1ns / 1ps

module char_lcd_nibble_bus_sequencer #(
	parameter int DELAY_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [2:0] mode, [10:3] data_byte, [15:11] zero
	input  logic [lcdseq_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [0] rs_level, [1] enable_level, [5:2] data_nibble, [6] busy_res, [7] accepted
	output logic [lcdseq_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lcdseq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lcdseq_pkg::CFG_DATA_W-1:0]  cfg_data
);

	lcdseq_pkg::entry_t front_entry;
	lcdseq_pkg::entry_t q_entry;
	logic               q_valid;
	logic               q_ready;

	lcdseq_front u_front (
		.s_tdata (s_tdata),
		.entry   (front_entry)
	);

	lcdseq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_entry  (front_entry),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_entry (q_entry)
	);

	lcdseq_back #(
		.DELAY_BITS (DELAY_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_entry   (q_entry),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ----- hw/rtl/lcdseq_checker.sv -----
// Port-level checks for the character LCD nibble bus sequencer.
`timescale 1ns / 1ps

module lcdseq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [lcdseq_pkg::OUT_DATA_W-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_enable_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[6])
		else $error("enable high while idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7] |-> m_tdata[6] && !m_tdata[1])
		else $error("accepted request not started with enable low");

	a_accept_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready ##1 m_tvalid && m_tdata[7] |-> !$past(m_tdata[6]))
		else $error("request accepted while busy");

endmodule

bind char_lcd_nibble_bus_sequencer lcdseq_checker u_lcdseq_checker (.*);
